// ----- hdl/pidis_pkg.sv -----
// Package for the integral-separation PID block: widths, register indexes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package pidis_pkg;

  localparam int unsigned DATA_W   = 16;  // Q8.8 samples and drive
  localparam int unsigned ERR_W    = 17;  // setpoint minus measured
  localparam int unsigned DIFF_W   = 18;  // error minus previous error
  localparam int unsigned SUM_W    = 24;  // Q16.8 error accumulator
  localparam int unsigned GAIN_W   = 16;  // Q4.12 gains, Q2.14 band
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BAND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_UPPER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LOWER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = 3'd7;

  localparam logic [GAIN_W-1:0]        RST_GAIN_P      = 16'd7373;
  localparam logic [GAIN_W-1:0]        RST_GAIN_I      = 16'd410;
  localparam logic [GAIN_W-1:0]        RST_GAIN_D      = 16'd0;
  localparam logic [GAIN_W-1:0]        RST_SEP_BAND    = 16'd2458;
  localparam logic signed [SUM_W-1:0]  RST_INT_UPPER   = 24'sd6144;
  localparam logic signed [SUM_W-1:0]  RST_INT_LOWER   = -24'sd6144;
  localparam logic signed [DATA_W-1:0] RST_DRIVE_UPPER = 16'sd9216;
  localparam logic signed [DATA_W-1:0] RST_DRIVE_LOWER = -16'sd9216;

  typedef struct packed {
    logic        [GAIN_W-1:0] gain_p;
    logic        [GAIN_W-1:0] gain_i;
    logic        [GAIN_W-1:0] gain_d;
    logic        [GAIN_W-1:0] sep_band;
    logic signed [SUM_W-1:0]  int_upper;
    logic signed [SUM_W-1:0]  int_lower;
    logic signed [DATA_W-1:0] drive_upper;
    logic signed [DATA_W-1:0] drive_lower;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;
    logic                     integral_on;
    logic signed [SUM_W-1:0]  error_sum;
    logic signed [ERR_W-1:0]  error;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/pid_integral_separation.sv -----
// Top level of the PID controller with integral separation and accumulator clamping.
// Usage:
//   Input channel (in_valid / in_stall) carries setpoint and measured, signed Q8.8.
//   A transfer happens on a rising edge with valid high and stall low.
//   Result channel (out_valid / out_stall) carries drive (Q8.8), saturated and
//   integral_on, one result per input transfer, in order.
//   A transferred sample waits in the input register, then moves to the result
//   register. One sample per cycle is sustained while out_stall is low; the error
//   accumulator and the previous error update in the single pass to the result register.
//   A stalled result holds in the output register while the input register
//   keeps the next sample; input stall rises only when both are full.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 gain_p, 1 gain_i, 2 gain_d, 3 separation_band, 4/5 integral upper/lower,
//   6/7 drive upper/lower); write only while no sample is in flight.
//   Reset (rst_n low, synchronous) loads the default gains and limits, clears
//   the accumulator and previous error and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module pid_integral_separation
  import pidis_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] in_setpoint,
  input  wire logic signed [DATA_W-1:0] in_measured,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_drive,
  output logic                          out_saturated,
  output logic                          out_integral_on,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DAT_W-1:0]     cfg_wdata
);

  cfg_t                     cfg_r;
  logic                     s1_valid_r;
  logic signed [DATA_W-1:0] s1_setpoint_r;
  logic signed [DATA_W-1:0] s1_measured_r;
  logic signed [SUM_W-1:0]  error_sum_r;
  logic signed [ERR_W-1:0]  prev_error_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_drive_r;
  logic                     out_saturated_r;
  logic                     out_integral_on_r;
  logic                     s1_valid_nxt;
  logic                     out_valid_nxt;
  logic                     in_xfer;
  logic                     s1_adv;
  logic                     band_on;
  res_t                     res;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= RST_GAIN_P;
      cfg_r.gain_i      <= RST_GAIN_I;
      cfg_r.gain_d      <= RST_GAIN_D;
      cfg_r.sep_band    <= RST_SEP_BAND;
      cfg_r.int_upper   <= RST_INT_UPPER;
      cfg_r.int_lower   <= RST_INT_LOWER;
      cfg_r.drive_upper <= RST_DRIVE_UPPER;
      cfg_r.drive_lower <= RST_DRIVE_LOWER;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_P:      cfg_r.gain_p      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:      cfg_r.gain_i      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      cfg_r.gain_d      <= cfg_wdata[GAIN_W-1:0];
        REG_SEP_BAND:    cfg_r.sep_band    <= cfg_wdata[GAIN_W-1:0];
        REG_INT_UPPER:   cfg_r.int_upper   <= signed'(cfg_wdata[SUM_W-1:0]);
        REG_INT_LOWER:   cfg_r.int_lower   <= signed'(cfg_wdata[SUM_W-1:0]);
        REG_DRIVE_UPPER: cfg_r.drive_upper <= signed'(cfg_wdata[DATA_W-1:0]);
        REG_DRIVE_LOWER: cfg_r.drive_lower <= signed'(cfg_wdata[DATA_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      error_sum_r  <= '0;
      prev_error_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // commit loop state only when the sample moves on to the result register
      if (s1_adv) begin
        error_sum_r  <= res.error_sum;
        prev_error_r <= res.error;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_setpoint_r <= in_setpoint;
      s1_measured_r <= in_measured;
    end
    if (s1_adv) begin
      out_drive_r       <= res.drive;
      out_saturated_r   <= res.saturated;
      out_integral_on_r <= res.integral_on;
    end
  end

  pidis_band u_band (
    .setpoint    (s1_setpoint_r),
    .measured    (s1_measured_r),
    .sep_band    (cfg_r.sep_band),
    .integral_on (band_on)
  );

  pidis_calc u_calc (
    .cfg         (cfg_r),
    .setpoint    (s1_setpoint_r),
    .measured    (s1_measured_r),
    .error_sum   (error_sum_r),
    .prev_error  (prev_error_r),
    .integral_on (band_on),
    .res         (res)
  );

  assign out_valid       = out_valid_r;
  assign out_drive       = out_drive_r;
  assign out_saturated   = out_saturated_r;
  assign out_integral_on = out_integral_on_r;

`ifndef SYNTHESIS
  a_stall_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a held sample and a held result");

  a_sat_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res.saturated) |->
      (res.drive == cfg_r.drive_upper || res.drive == cfg_r.drive_lower))
    else $error("saturated drive is not one of the drive limits");

  a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (cfg_r.int_lower <= cfg_r.int_upper)) |=>
      (error_sum_r <= $past(cfg_r.int_upper) && error_sum_r >= $past(cfg_r.int_lower)))
    else $error("error accumulator left its clamp range");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(error_sum_r) && $stable(prev_error_r)))
    else $error("loop state changed without a sample moving on");
`endif

endmodule

`default_nettype wire

// ----- hdl/pidis_band.sv -----
// Integral separation test: measured strictly inside setpoint*(1-band)..setpoint*(1+band).
`timescale 1ns / 1ps
`default_nettype none

module pidis_band
  import pidis_pkg::*;
(
  input  wire logic signed [DATA_W-1:0] setpoint,
  input  wire logic signed [DATA_W-1:0] measured,
  input  wire logic        [GAIN_W-1:0] sep_band,
  output logic                          integral_on
);

  localparam logic [DIFF_W-1:0] ONE_Q14 = 18'd16384;

  logic signed [DIFF_W-1:0]        lo_k;
  logic signed [DIFF_W-1:0]        hi_k;
  logic signed [DATA_W+DIFF_W-1:0] lo_bound;
  logic signed [DATA_W+DIFF_W-1:0] hi_bound;
  logic signed [DATA_W+DIFF_W-1:0] meas_q14;

  // 1-band can go negative, 1+band stays below 2^17: both fit 18 signed bits
  assign lo_k = signed'(ONE_Q14 - {2'b00, sep_band});
  assign hi_k = signed'(ONE_Q14 + {2'b00, sep_band});

  assign lo_bound = setpoint * lo_k;
  assign hi_bound = setpoint * hi_k;
  assign meas_q14 = signed'({{(DIFF_W-14){measured[DATA_W-1]}}, measured, 14'd0});

  assign integral_on = (meas_q14 > lo_bound) && (meas_q14 < hi_bound);

endmodule

`default_nettype wire

// ----- hdl/pidis_calc.sv -----
// PID datapath: error, clamped accumulator, floored gain products and drive saturation.
`timescale 1ns / 1ps
`default_nettype none

module pidis_calc
  import pidis_pkg::*;
(
  input  wire cfg_t                     cfg,
  input  wire logic signed [DATA_W-1:0] setpoint,
  input  wire logic signed [DATA_W-1:0] measured,
  input  wire logic signed [SUM_W-1:0]  error_sum,
  input  wire logic signed [ERR_W-1:0]  prev_error,
  input  wire logic                     integral_on,
  output res_t                          res
);

  localparam int unsigned GS_W  = GAIN_W + 1;
  localparam int unsigned PP_W  = GS_W + ERR_W;
  localparam int unsigned IP_W  = GS_W + SUM_W;
  localparam int unsigned DP_W  = GS_W + DIFF_W;
  localparam int unsigned ACC_W = 31;

  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_raw;
  logic signed [SUM_W-1:0]  sum_clamp;
  logic signed [DIFF_W-1:0] diff;
  logic signed [GS_W-1:0]   gp_s;
  logic signed [GS_W-1:0]   gi_s;
  logic signed [GS_W-1:0]   gd_s;
  logic signed [PP_W-1:0]   p_full;
  logic signed [IP_W-1:0]   i_full;
  logic signed [DP_W-1:0]   d_full;
  logic        [PP_W-13:0]  p_term;
  logic        [IP_W-13:0]  i_term;
  logic        [DP_W-13:0]  d_term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  dr_hi;
  logic signed [ACC_W-1:0]  dr_lo;

  assign err = {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};

  assign sum_raw = {error_sum[SUM_W-1], error_sum}
                 + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};

  // upper limit wins, so crossed limits always land on one of them
  always_comb begin
    if (sum_raw > signed'({cfg.int_upper[SUM_W-1], cfg.int_upper})) begin
      sum_clamp = cfg.int_upper;
    end else if (sum_raw < signed'({cfg.int_lower[SUM_W-1], cfg.int_lower})) begin
      sum_clamp = cfg.int_lower;
    end else begin
      sum_clamp = sum_raw[SUM_W-1:0];
    end
  end

  assign diff = {err[ERR_W-1], err} - {prev_error[ERR_W-1], prev_error};

  assign gp_s = signed'({1'b0, cfg.gain_p});
  assign gi_s = signed'({1'b0, cfg.gain_i});
  assign gd_s = signed'({1'b0, cfg.gain_d});

  assign p_full = gp_s * err;
  assign i_full = gi_s * sum_clamp;
  assign d_full = gd_s * diff;

  // drop 12 fraction bits of two's complement: floor toward minus infinity
  assign p_term = p_full[PP_W-1:12];
  assign i_term = i_full[IP_W-1:12];
  assign d_term = d_full[DP_W-1:12];

  always_comb begin
    acc = signed'({{(ACC_W-PP_W+12){p_term[PP_W-13]}}, p_term})
        + signed'({{(ACC_W-DP_W+12){d_term[DP_W-13]}}, d_term});
    if (integral_on) begin
      acc = acc + signed'({{(ACC_W-IP_W+12){i_term[IP_W-13]}}, i_term});
    end
  end

  assign dr_hi = signed'({{(ACC_W-DATA_W){cfg.drive_upper[DATA_W-1]}}, cfg.drive_upper});
  assign dr_lo = signed'({{(ACC_W-DATA_W){cfg.drive_lower[DATA_W-1]}}, cfg.drive_lower});

  always_comb begin
    res.error_sum   = sum_clamp;
    res.error       = err;
    res.integral_on = integral_on;
    if (acc > dr_hi) begin
      res.drive     = cfg.drive_upper;
      res.saturated = 1'b1;
    end else if (acc < dr_lo) begin
      res.drive     = cfg.drive_lower;
      res.saturated = 1'b1;
    end else begin
      res.drive     = acc[DATA_W-1:0];
      res.saturated = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- verif/pid_integral_separation_tb.sv -----
// Self-checking testbench for the integral-separation PID block: directed table plus random phases.
`timescale 1ns / 1ps

module pid_integral_separation_tb;
  import pidis_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int MAX_GAP         = 5;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 7;
  localparam int LONG_HOLD       = 64;
  localparam int LONG_HOLD_AT    = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 40;
  localparam int NUM_DIRECTED    = 23;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;
    logic                     integral_on;
  } drive_res_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic                     known;
    drive_res_t               typed;
  } sample_row_t;

  localparam drive_res_t NO_RES = '0;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_setpoint = '0;
  logic signed [DATA_W-1:0] in_measured = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic signed [DATA_W-1:0] out_drive;
  logic                     out_saturated;
  logic                     out_integral_on;
  logic                     cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index   = '0;
  logic [CFG_DAT_W-1:0]     cfg_wdata   = '0;

  // Controller copy: settings, error accumulator and last error.
  cfg_t       ctl_cfg;
  longint     err_sum;
  longint     last_err;
  drive_res_t pending_drives[$];

  int mismatches   = 0;
  int accepted_cnt = 0;
  int results_cnt  = 0;
  int stall_cycles = 0;
  int sat_cnt      = 0;
  int ion_cnt      = 0;
  bit gaps_on      = 1'b1;

  logic signed [DATA_W-1:0] corner_vals [0:4] =
    '{16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};

  // Rows run from reset under the default settings.
  sample_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{16'sd0,      16'sd0,      1'b1, '{16'sd0,     1'b0, 1'b0}},
    '{16'sd32767,  -16'sd32768, 1'b1, '{16'sd9216,  1'b1, 1'b0}},
    '{-16'sd32768, 16'sd32767,  1'b1, '{-16'sd9216, 1'b1, 1'b0}},
    '{16'sd32767,  16'sd32767,  1'b0, NO_RES},
    '{-16'sd32768, -16'sd32768, 1'b1, '{16'sd0,     1'b0, 1'b0}},
    '{-16'sd1000,  -16'sd1000,  1'b1, '{16'sd0,     1'b0, 1'b0}},
    '{16'sd0,      16'sd5,      1'b0, NO_RES},
    '{16'sd0,      -16'sd5,     1'b0, NO_RES},
    // band edges: equal to a bound is outside
    '{16'sd16384,  16'sd13926,  1'b0, NO_RES},
    '{16'sd16384,  16'sd13927,  1'b0, NO_RES},
    '{16'sd16384,  16'sd18842,  1'b0, NO_RES},
    '{16'sd16384,  16'sd18841,  1'b0, NO_RES},
    // drive the accumulator into its upper clamp with the integral term off
    '{16'sd5000,   16'sd0,      1'b0, NO_RES},
    '{16'sd5000,   16'sd0,      1'b0, NO_RES},
    '{16'sd5000,   16'sd0,      1'b0, NO_RES},
    '{16'sd1000,   16'sd1000,   1'b0, NO_RES},
    // and down into the lower clamp
    '{16'sd0,      16'sd5000,   1'b0, NO_RES},
    '{16'sd0,      16'sd5000,   1'b0, NO_RES},
    '{16'sd0,      16'sd5000,   1'b0, NO_RES},
    '{16'sd0,      16'sd5000,   1'b0, NO_RES},
    '{16'sd1000,   16'sd1000,   1'b0, NO_RES},
    '{-16'sd1,     16'sd0,      1'b0, NO_RES},
    '{16'sd256,    16'sd230,    1'b0, NO_RES}
  };

  pid_integral_separation DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_setpoint     (in_setpoint),
    .in_measured     (in_measured),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive       (out_drive),
    .out_saturated   (out_saturated),
    .out_integral_on (out_integral_on),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // One controller step: update the accumulator and last error, return the drive.
  function automatic drive_res_t step_controller(input logic signed [DATA_W-1:0] sp,
                                                 input logic signed [DATA_W-1:0] ms);
    drive_res_t r;
    longint e, band_lo, band_hi, ms14, acc, lim_hi, lim_lo;
    e       = longint'(sp) - longint'(ms);
    band_lo = longint'(sp) * (16384 - longint'(ctl_cfg.sep_band));
    band_hi = longint'(sp) * (16384 + longint'(ctl_cfg.sep_band));
    ms14    = longint'(ms) * 16384;
    r.integral_on = (ms14 > band_lo) && (ms14 < band_hi);

    lim_hi  = longint'($signed(ctl_cfg.int_upper));
    lim_lo  = longint'($signed(ctl_cfg.int_lower));
    err_sum = err_sum + e;
    if (err_sum > lim_hi) begin
      err_sum = lim_hi;
    end else if (err_sum < lim_lo) begin
      err_sum = lim_lo;
    end

    // each product floors to Q8.8 on its own
    acc = (longint'(ctl_cfg.gain_p) * e) >>> 12;
    if (r.integral_on) begin
      acc = acc + ((longint'(ctl_cfg.gain_i) * err_sum) >>> 12);
    end
    acc = acc + ((longint'(ctl_cfg.gain_d) * (e - last_err)) >>> 12);

    lim_hi = longint'($signed(ctl_cfg.drive_upper));
    lim_lo = longint'($signed(ctl_cfg.drive_lower));
    r.saturated = 1'b1;
    if (acc > lim_hi) begin
      acc = lim_hi;
    end else if (acc < lim_lo) begin
      acc = lim_lo;
    end else begin
      r.saturated = 1'b0;
    end
    r.drive  = acc[DATA_W-1:0];
    last_err = e;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic offer_sample(input sample_row_t row);
    drive_res_t predicted;
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_setpoint <= row.setpoint;
    in_measured <= row.measured;
    @(posedge clk);
    while (in_stall) begin
      stall_cycles++;
      @(posedge clk);
    end
    accepted_cnt++;
    predicted = step_controller(row.setpoint, row.measured);
    pending_drives.push_back(row.known ? row.typed : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold the write enable high across back-to-back writes; the caller drops it.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    put_reg(REG_GAIN_P,      {junk, s.gain_p});
    put_reg(REG_GAIN_I,      {~junk, s.gain_i});
    put_reg(REG_GAIN_D,      {junk, s.gain_d});
    put_reg(REG_SEP_BAND,    {~junk, s.sep_band});
    put_reg(REG_INT_UPPER,   s.int_upper);
    put_reg(REG_INT_LOWER,   s.int_lower);
    put_reg(REG_DRIVE_UPPER, {junk, s.drive_upper});
    put_reg(REG_DRIVE_LOWER, {~junk, s.drive_lower});
    cfg_wr_en <= 1'b0;
    ctl_cfg = s;
  endtask

  initial begin : result_sink
    drive_res_t want;
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_cnt++;
        if (pending_drives.size() == 0) begin
          report_mismatch($sformatf("unexpected result, drive %0d", out_drive));
        end else begin
          want = pending_drives.pop_front();
          if (out_drive !== want.drive) begin
            report_mismatch($sformatf("result %0d drive %0d, predicted %0d",
                                      results_cnt, out_drive, want.drive));
          end
          if (out_saturated !== want.saturated) begin
            report_mismatch($sformatf("result %0d saturated %b, predicted %b",
                                      results_cnt, out_saturated, want.saturated));
          end
          if (out_integral_on !== want.integral_on) begin
            report_mismatch($sformatf("result %0d integral_on %b, predicted %b",
                                      results_cnt, out_integral_on, want.integral_on));
          end
        end
        if (out_saturated === 1'b1) sat_cnt++;
        if (out_integral_on === 1'b1) ion_cnt++;
        // one long hold-off lets the block fill and push back on its input
        if (results_cnt == LONG_HOLD_AT) begin
          hold = LONG_HOLD;
        end else begin
          hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        end
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run exceeded %0d cycles with %0d results outstanding.",
             CYCLE_LIMIT, pending_drives.size());
    $display("** pid_integral_separation: FAILED **");
    $finish;
  end

  initial begin : stimulus
    cfg_t        plan [NUM_PHASES];
    sample_row_t row;
    int          span;
    int          dev;

    ctl_cfg = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                sep_band: RST_SEP_BAND, int_upper: RST_INT_UPPER, int_lower: RST_INT_LOWER,
                drive_upper: RST_DRIVE_UPPER, drive_lower: RST_DRIVE_LOWER};
    err_sum  = 0;
    last_err = 0;

    plan[0] = ctl_cfg;
    plan[1] = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF, sep_band: 16'hFFFF,
                int_upper: 24'sh7FFFFF, int_lower: 24'sh800000,
                drive_upper: 16'sh7FFF, drive_lower: 16'sh8000};
    // crossed limits on both the accumulator and the drive, band of exactly one
    plan[2] = '{gain_p: 16'd4096, gain_i: 16'd8192, gain_d: 16'd2048, sep_band: 16'd16384,
                int_upper: -24'sd1000, int_lower: 24'sd1000,
                drive_upper: -16'sd500, drive_lower: 16'sd500};
    plan[3] = '0;
    plan[4] = '{gain_p: GAIN_W'($urandom), gain_i: GAIN_W'($urandom),
                gain_d: GAIN_W'($urandom), sep_band: GAIN_W'($urandom),
                int_upper: SUM_W'($urandom), int_lower: SUM_W'($urandom),
                drive_upper: DATA_W'($urandom), drive_lower: DATA_W'($urandom)};
    plan[5] = ctl_cfg;
    plan[5].gain_d   = 16'd4096;
    plan[5].sep_band = 16'd20000;
    plan[6] = '{gain_p: GAIN_W'($urandom), gain_i: GAIN_W'($urandom),
                gain_d: GAIN_W'($urandom),
                sep_band: GAIN_W'($urandom_range(0, 20000)),
                int_upper: SUM_W'($urandom_range(0, 65535)),
                int_lower: SUM_W'(-$urandom_range(0, 65535)),
                drive_upper: DATA_W'($urandom_range(0, 32767)),
                drive_lower: DATA_W'(-$urandom_range(0, 32767))};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_sample(directed_rows[i]);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        load_settings(plan[ph]);
      end
      gaps_on = (ph % 3 != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        row.known = 1'b0;
        row.typed = NO_RES;
        case ($urandom_range(0, 9))
          0, 1: begin
            row.setpoint = DATA_W'($urandom_range(0, 65535));
            row.measured = DATA_W'($urandom_range(0, 65535));
          end
          2: begin
            row.setpoint = corner_vals[$urandom_range(0, 4)];
            row.measured = corner_vals[$urandom_range(0, 4)];
          end
          3: begin
            span = $urandom_range(0, 511);
            dev  = $urandom_range(0, 511);
            row.setpoint = DATA_W'(span - 256);
            row.measured = DATA_W'(dev - 256);
          end
          default: begin
            // measured settling around the target, mostly inside the band
            span = $urandom_range(1, 16000);
            dev  = $urandom_range(0, span / 2);
            dev  = dev - span / 4;
            if ($urandom_range(0, 3) == 0) begin
              span = -span;
            end
            row.setpoint = DATA_W'(span);
            row.measured = DATA_W'(span + dev);
          end
        endcase
        offer_sample(row);
      end
    end

    drain_results();

    $display("Sent %0d samples (%0d from the table) across %0d gain and limit settings.",
             accepted_cnt, NUM_DIRECTED, NUM_PHASES);
    $display("Checked %0d results: %0d saturated, %0d with integral term; input held %0d cycles.",
             results_cnt, sat_cnt, ion_cnt, stall_cycles);
    if (mismatches == 0) begin
      $display("** pid_integral_separation: PASSED **");
    end else begin
      $display("** pid_integral_separation: FAILED **");
    end
    $finish;
  end

endmodule
